@@ rtl/core/bb3_pkg.sv @@
// shared types, constants and helpers of the 3x3 box blur stream core
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int POS_LIMIT     = 1024;

    localparam int PIX_W = 24;
    localparam int POS_W = 10;
    localparam int CFG_W = 11;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd800;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd600;

    // register indexes of the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [11:0] DIV9_MUL     = 12'd3641;
    localparam int          DIV9_SHIFT   = 15;

    // position and pending-result info of one pixel
    // mask bit {ci,ri}: ci picks column c-1 or c, ri picks row r-1 or r
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [3:0]       mask;
        logic             top_ok;
        logic             mid_ok;
        logic             first_col;
    } bb3_pos_t;

    // per column and channel: rows 1..2 (part) and rows 0..2 (full)
    typedef logic [2:0][2:0][9:0] bb3_csum_t;

    typedef struct packed {
        bb3_csum_t full;
        bb3_csum_t part;
    } bb3_sums_t;

    // floor(x / 9), exact for x below 2304, whose quotients fit in 8 bits
    function automatic logic [7:0] div9(input logic [11:0] x);
        logic [23:0] prod;
        prod = 24'(x) * 24'(DIV9_MUL);
        return prod[DIV9_SHIFT+7:DIV9_SHIFT];
    endfunction

endpackage

@@ rtl/core/box_blur_3x3_stream_core.sv @@
// top level of the streaming 3x3 box blur core
// Streaming 3x3 box blur over RGBA8888 pixels in raster order. One pixel is taken per
// clock; the result for pixel (c-1, r-1) passes the window, sum and output registers
// after pixel (c, r) is transferred. The output register moves one result per clock
// while m_tready is high, so a pixel that yields several results holds the result stage
// until all are sent and stalls the input meanwhile: in frames of at least two by two the
// last column gives two from the second row on, the last row gives two from the second
// column on and the last pixel of a frame gives four. Sustained rate is therefore one
// pixel per clock inside the frame. The two previous rows live in two line store banks of
// MAX_WIDTH entries read and written at the pixel column in the transfer cycle; the
// window update with its column sums and the divide by nine follow in one stage each.
// frame_start on tuser restarts at column 0, row 0. Frame size is clamped to
// 1..min(MAX_WIDTH,1024) by 1..1024; the user must write it only while idle (unchecked).
module box_blur_3x3_stream_core
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // pixel_in[31:0]
    input  logic             s_tuser,   // frame_start
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,   // pixel_out[31:0], out_col[41:32], out_row[51:42], pad
    output logic             m_tlast    // last_of_run
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WMAX   = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [POS_W-1:0] col_count_reg;
    logic [POS_W-1:0] col_count_next;
    logic [POS_W-1:0] row_count_reg;
    logic [POS_W-1:0] row_count_next;

    logic             s1_valid_reg;
    bb3_pos_t         s1_pos_reg;
    logic [PIX_W-1:0] s1_cur_reg;

    logic [CFG_W-1:0] w_clamp;
    logic [CFG_W-1:0] h_clamp;
    logic [POS_W-1:0] wm1;
    logic [POS_W-1:0] hm1;
    logic [POS_W-1:0] c_pre;
    logic [POS_W-1:0] r_pre;
    logic [POS_W-1:0] c;
    logic [POS_W-1:0] r;
    logic             lastc;
    logic             lastr;
    bb3_pos_t         pos;

    logic             accept;
    logic             s1_adv;
    logic             s2_ready;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    bb3_sums_t        sums;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
            endcase
        end
    end

    // frame size clamp and position of the incoming pixel
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_clamp = 11'd1;
        end
        else if (frame_width_reg > 11'(WMAX))
        begin
            w_clamp = 11'(WMAX);
        end
        else
        begin
            w_clamp = frame_width_reg;
        end

        if (frame_height_reg == '0)
        begin
            h_clamp = 11'd1;
        end
        else if (frame_height_reg > 11'(POS_LIMIT))
        begin
            h_clamp = 11'(POS_LIMIT);
        end
        else
        begin
            h_clamp = frame_height_reg;
        end

        wm1   = 10'(w_clamp - 11'd1);
        hm1   = 10'(h_clamp - 11'd1);
        c_pre = s_tuser ? '0 : col_count_reg;
        r_pre = s_tuser ? '0 : row_count_reg;
        c     = (c_pre > wm1) ? wm1 : c_pre;
        r     = (r_pre > hm1) ? hm1 : r_pre;
        lastc = (c == wm1);
        lastr = (r == hm1);

        pos.col       = c;
        pos.row       = r;
        pos.mask[0]   = (c != '0) && (r != '0);
        pos.mask[1]   = (c != '0) && lastr;
        pos.mask[2]   = lastc && (r != '0);
        pos.mask[3]   = lastc && lastr;
        pos.top_ok    = (r >= 10'd2);
        pos.mid_ok    = (r != '0);
        pos.first_col = (c == '0);

        if (lastc)
        begin
            col_count_next = '0;
            row_count_next = lastr ? '0 : r + 10'd1;
        end
        else
        begin
            col_count_next = c + 10'd1;
            row_count_next = r;
        end
    end

    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s_tready = !s1_valid_reg || s2_ready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= pos;
            s1_cur_reg <= s_tdata[31:8];
        end
    end

    bb3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .en    (accept),
        .addr  (ADDR_W'(c)),
        .bank  (r[0]),
        .wdata (s_tdata[31:8]),
        .top   (top),
        .mid   (mid)
    );

    bb3_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_adv),
        .pos     (s1_pos_reg),
        .top     (top),
        .mid     (mid),
        .cur     (s1_cur_reg),
        .sums    (sums)
    );

    bb3_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_adv),
        .pos      (s1_pos_reg),
        .sums     (sums),
        .ready    (s2_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // column counter stays inside the widest supported row
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_count_reg} < 11'(WMAX))
        else $error("column counter beyond line store width");

    // a stalled pixel in the memory stage keeps its position
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_pos_reg))
        else $error("memory stage pixel lost while stalled");

    // a frame start transfer restarts the column count
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser |=> col_count_reg <= 10'd1)
        else $error("frame start did not restart the column counter");

endmodule

@@ rtl/core/bb3_line_store.sv @@
// two line store banks, one per row parity, read and written at the pixel column
module bb3_line_store
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  logic                         bank,
    input  logic [PIX_W-1:0]             wdata,
    output logic [PIX_W-1:0]             top,
    output logic [PIX_W-1:0]             mid
);

    logic [PIX_W-1:0] bank0_mem [MAX_WIDTH];
    logic [PIX_W-1:0] bank1_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd0_reg;
    logic [PIX_W-1:0] rd1_reg;
    logic             bank_reg;

    // read returns the old entry, the current row overwrites it afterwards
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd0_reg <= bank0_mem[addr];
            if (!bank)
            begin
                bank0_mem[addr] <= wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd1_reg <= bank1_mem[addr];
            if (bank)
            begin
                bank1_mem[addr] <= wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bank_reg <= bank;
        end
    end

    // the bank of the current row parity holds row r-2, the other row r-1
    assign top = bank_reg ? rd1_reg : rd0_reg;
    assign mid = bank_reg ? rd0_reg : rd1_reg;

endmodule

@@ rtl/core/bb3_window.sv @@
// 3x3 window registers and the column sums of the updated window
module bb3_window
    import bb3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  bb3_pos_t         pos,
    input  logic [PIX_W-1:0] top,
    input  logic [PIX_W-1:0] mid,
    input  logic [PIX_W-1:0] cur,
    output bb3_sums_t        sums
);

    logic [2:0][2:0][PIX_W-1:0] win_reg;
    logic [2:0][2:0][PIX_W-1:0] win_next;

    always_comb
    begin
        win_next = win_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (pos.first_col)
            begin
                win_next[k][0] = '0;
                win_next[k][1] = '0;
            end
            else
            begin
                win_next[k][0] = win_reg[k][1];
                win_next[k][1] = win_reg[k][2];
            end
        end
        win_next[0][2] = pos.top_ok ? top : '0;
        win_next[1][2] = pos.mid_ok ? mid : '0;
        win_next[2][2] = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (advance)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                sums.part[j][ch] = 10'(win_next[1][j][ch*8 +: 8])
                                 + 10'(win_next[2][j][ch*8 +: 8]);
                sums.full[j][ch] = sums.part[j][ch] + 10'(win_next[0][j][ch*8 +: 8]);
            end
        end
    end

endmodule

@@ rtl/core/bb3_emit.sv @@
// result sequencer: up to four results per pixel, divide by nine, output register
module bb3_emit
    import bb3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  bb3_pos_t    pos,
    input  bb3_sums_t   sums,
    output logic        ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // pixel_out[31:0], out_col[41:32], out_row[51:42], zero pad
    output logic        m_tlast     // last_of_run
);

    logic [3:0]       mask_reg;
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_reg;
    bb3_sums_t        sums_reg;

    logic             out_valid_reg;
    logic [31:0]      out_pixel_reg;
    logic [POS_W-1:0] out_col_reg;
    logic [POS_W-1:0] out_row_reg;
    logic             out_last_reg;

    logic [1:0]       sel;
    logic             emit;
    logic [3:0]       mask_after;
    logic [2:0][7:0]  quot;
    logic [POS_W-1:0] res_col;
    logic [POS_W-1:0] res_row;

    // lowest pending result first: by column, then by row
    always_comb
    begin
        priority if (mask_reg[0])
        begin
            sel = 2'd0;
        end
        else if (mask_reg[1])
        begin
            sel = 2'd1;
        end
        else if (mask_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
    end

    assign emit       = (mask_reg != 4'd0) && (!out_valid_reg || m_tready);
    assign mask_after = emit ? (mask_reg & ~(4'd1 << sel)) : mask_reg;
    assign ready      = (mask_after == 4'd0);

    always_comb
    begin
        logic [11:0] tot;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (sel[0])
            begin
                tot = 12'(sums_reg.part[1][ch]) + 12'(sums_reg.part[2][ch])
                    + (sel[1] ? 12'd0 : 12'(sums_reg.part[0][ch]));
            end
            else
            begin
                tot = 12'(sums_reg.full[1][ch]) + 12'(sums_reg.full[2][ch])
                    + (sel[1] ? 12'd0 : 12'(sums_reg.full[0][ch]));
            end
            quot[ch] = div9(tot);
        end
    end

    assign res_col = sel[1] ? col_reg : col_reg - 10'd1;
    assign res_row = sel[0] ? row_reg : row_reg - 10'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (load)
        begin
            mask_reg <= pos.mask;
        end
        else
        begin
            mask_reg <= mask_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg  <= pos.col;
            row_reg  <= pos.row;
            sums_reg <= sums;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pixel_reg <= {quot[2], quot[1], quot[0], ALPHA_OPAQUE};
            out_col_reg   <= res_col;
            out_row_reg   <= res_row;
            out_last_reg  <= (mask_after == 4'd0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_row_reg, out_col_reg, out_pixel_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ verif/box_blur_3x3_stream_core_tb.sv @@
// self-checking testbench of the 3x3 box blur stream core with its own pixel-level predictor
module box_blur_3x3_stream_core_tb;
    import bb3_pkg::*;

    localparam int LINE_LEN      = MAX_WIDTH_DEF;
    localparam int WIDTH_MAX     = (MAX_WIDTH_DEF < POS_LIMIT) ? MAX_WIDTH_DEF : POS_LIMIT;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_PIXELS = 70;
    localparam int PRINT_CAP     = 100;

    typedef struct packed {
        logic [31:0]      pixel;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } blur_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [31:0]      s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [55:0]      m_tdata;
    logic             m_tlast;

    // predictor state
    logic [PIX_W-1:0] line_mem [0:2*LINE_LEN-1];
    logic [PIX_W-1:0] win [0:2][0:2];
    int unsigned      next_col;
    int unsigned      next_row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    blur_result_t     pending_blurs[$];

    bit          stall_on = 1'b1;
    int unsigned ready_hold = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes = 0;

    box_blur_3x3_stream_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // mean over window rows r0..2 and columns c0..2, missing neighbors count as zero
    function automatic logic [31:0] window_mean(input int c0, input int r0);
        int unsigned sr = 0;
        int unsigned sg = 0;
        int unsigned sb = 0;
        for (int i = r0; i < 3; i++)
            for (int j = c0; j < 3; j++)
            begin
                sr += win[i][j][23:16];
                sg += win[i][j][15:8];
                sb += win[i][j][7:0];
            end
        return {8'(sr / 9), 8'(sg / 9), 8'(sb / 9), ALPHA_OPAQUE};
    endfunction

    task automatic predict_blur(input logic [31:0] pix, input logic frame_start);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        int unsigned      n;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        bit               lastc;
        bit               lastr;
        blur_result_t     res;
        w = clamp_size(width_reg, WIDTH_MAX);
        h = clamp_size(height_reg, POS_LIMIT);
        if (frame_start)
        begin
            next_col = 0;
            next_row = 0;
        end
        // a frame shrunk under the current position pins it to the last column and row
        if (next_col > w - 1)
            next_col = w - 1;
        if (next_row > h - 1)
            next_row = h - 1;
        c = next_col;
        r = next_row;
        lastc = (c == w - 1);
        lastr = (r == h - 1);
        top = (r >= 2) ? line_mem[(r % 2) * LINE_LEN + c] : '0;
        mid = (r >= 1) ? line_mem[((r + 1) % 2) * LINE_LEN + c] : '0;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = (c == 0) ? '0 : win[k][1];
            win[k][1] = (c == 0) ? '0 : win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix[31:8];
        line_mem[(r % 2) * LINE_LEN + c] = pix[31:8];
        n = 0;
        // column c-1 before column c, row r-1 before row r
        for (int ci = 0; ci < 2; ci++)
            for (int ri = 0; ri < 2; ri++)
                if (!(ci == 0 && c == 0) && !(ci == 1 && !lastc) &&
                    !(ri == 0 && r == 0) && !(ri == 1 && !lastr))
                begin
                    res.pixel = window_mean(ci, ri);
                    res.col   = POS_W'((ci == 0) ? c - 1 : c);
                    res.row   = POS_W'((ri == 0) ? r - 1 : r);
                    res.last  = 1'b0;
                    pending_blurs.push_back(res);
                    n++;
                end
        if (n > 0)
        begin
            res = pending_blurs.pop_back();
            res.last = 1'b1;
            pending_blurs.push_back(res);
        end
        if (lastc)
        begin
            next_col = 0;
            next_row = lastr ? 0 : r + 1;
        end
        else
            next_col = c + 1;
        pixels_sent++;
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic send_pixel(input logic [31:0] pix, input logic frame_start);
        int unsigned gap;
        gap = (stall_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= frame_start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_blur(pix, frame_start);
    endtask

    // first pixel opens a frame, later ones restart it with odds 1 in restart_odds
    task automatic send_frame(input int unsigned count, input int unsigned restart_odds);
        bit fs;
        for (int unsigned i = 0; i < count; i++)
        begin
            fs = (i == 0) || (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
            send_pixel($urandom(), fs);
        end
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_blurs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        cfg_writes++;
    endtask

    task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_drain();
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
    endtask

    // 3x3 frames hit every border case: first and last column, last row, final pixel
    task automatic test_corner_pixels();
        stall_on = 1'b0;
        set_frame_size(11'd3, 11'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(32'hFFFF_FFFF, i == 0);
        // all-zero frame cut short by a new frame start
        for (int i = 0; i < 4; i++)
            send_pixel(32'h0000_0000, i == 0);
        stall_on = 1'b1;
        for (int i = 0; i < 9; i++)
            send_pixel({8'(i * 28), 8'(255 - i * 28), 8'(i * 7 + 3), 8'h5A}, i == 0);
    endtask

    task automatic test_size_clamping();
        set_frame_size(11'd0, 11'd0);          // both clamped up to one
        send_frame(3, 0);
        set_frame_size(11'd2047, 11'd1);       // width clamped to the line length
        send_frame(8, 0);
        set_frame_size(11'd3, 11'd2047);       // height clamped to the row limit
        send_frame(9, 0);
        set_frame_size(11'd2, 11'd1);
        send_frame(4, 0);
    endtask

    task automatic test_shrunk_frame();
        set_frame_size(11'd6, 11'd5);
        send_frame(23, 0);                     // stops before row 3, column 5
        set_frame_size(11'd4, 11'd3);          // position now past both edges
        for (int i = 0; i < 13; i++)
            send_pixel($urandom(), 1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned odds;
        int unsigned kind;
        int unsigned start;
        bit          fresh;
        start = pixels_sent;
        fresh = 1'b1;
        stall_on = 1'b1;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            if (fresh || $urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    w = $urandom_range(17, 64);
                    h = $urandom_range(1, 3);
                end
                else
                begin
                    w = $urandom_range(1, 16);
                    h = $urandom_range(1, 6);
                end
                set_frame_size(CFG_W'(w), CFG_W'(h));
                fresh = 1'b0;
            end
            n = w * h;
            odds = 0;
            kind = $urandom_range(0, 9);
            if (kind == 0 && n > 1)
                n = $urandom_range(1, n - 1);
            else if (kind == 1)
                odds = 6;
            if (n > RANDOM_PIXELS - (pixels_sent - start))
                n = RANDOM_PIXELS - (pixels_sent - start);
            if (pixels_sent - start >= RANDOM_PIXELS * 3 / 4)
                stall_on = 1'b0;
            send_frame(n, odds);
        end
    endtask

    // sink side: random back-pressure bursts
    always @(negedge clk)
    begin
        if (ready_hold != 0)
            ready_hold--;
        else if (stall_on && $urandom_range(0, 5) == 0)
            ready_hold = $urandom_range(1, 17);
        m_tready <= (ready_hold == 0);
    end

    always @(posedge clk)
    begin : check_result
        blur_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (pending_blurs.size() == 0)
                report_mismatch($sformatf("result %h with nothing expected", m_tdata));
            else
            begin
                want = pending_blurs.pop_front();
                if (m_tdata[31:0] !== want.pixel)
                    report_mismatch($sformatf("pixel_out %h, want %h", m_tdata[31:0], want.pixel));
                if (m_tdata[41:32] !== want.col)
                    report_mismatch($sformatf("out_col %0d, want %0d", m_tdata[41:32], want.col));
                if (m_tdata[51:42] !== want.row)
                    report_mismatch($sformatf("out_row %0d, want %0d", m_tdata[51:42], want.row));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_of_run %b, want %b", m_tlast, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("box_blur_3x3_stream_core test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        for (int i = 0; i < 2 * LINE_LEN; i++)
            line_mem[i] = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        next_col   = 0;
        next_row   = 0;
        width_reg  = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_pixels();
        test_size_clamping();
        test_shrunk_frame();
        test_random_frames();
        wait_drain();

        $display("summary: %0d pixels transferred, %0d blurred results checked, %0d register writes",
                 pixels_sent, results_checked, cfg_writes);
        $display("summary: border cases, zero and oversized sizes, restarts, mid-frame shrink");
        if (mismatch_count == 0)
            $display("box_blur_3x3_stream_core test passed");
        else
            $display("box_blur_3x3_stream_core test failed");
        $finish;
    end

endmodule
